>>> rtl/core/etpq_pkg.sv
// shared types and constants for the event time priority queue
`timescale 1ns / 1ps
`default_nettype none

package etpq_pkg;

  localparam int CAPACITY  = 64;
  localparam int TIME_BITS = 20;
  localparam int TIME_W    = 20;
  localparam int KIND_W    = 4;
  localparam int DATA_W    = 16;
  localparam int CNT_W     = $clog2(CAPACITY + 1);

  typedef enum logic [0:0] {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [TIME_BITS-1:0] ev_time;
    logic [KIND_W-1:0]    kind;
    logic [DATA_W-1:0]    pa;
    logic [DATA_W-1:0]    pb;
  } entry_t;

  typedef struct packed {
    logic latch;
    logic apply;
  } ctrl_cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/etpq_ctrl.sv
// controller: handshake sequencing and output word valid
`timescale 1ns / 1ps
`default_nettype none

module etpq_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output etpq_pkg::ctrl_cmd_t    cmd_o
);

  typedef enum logic [0:0] {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   accept;
  logic   out_free;

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o.latch = accept;
    cmd_o.apply = (state_q == S_EXEC) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
          if (accept) state_q <= S_EXEC;
        end
        S_EXEC: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/etpq_dp.sv
// datapath: sorted shift register of events with per-slot compare
`timescale 1ns / 1ps
`default_nettype none

module etpq_dp (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire etpq_pkg::ctrl_cmd_t             cmd_i,
  input  wire logic                            command_i,
  input  wire logic [etpq_pkg::TIME_W-1:0]     event_time_i,
  input  wire logic [etpq_pkg::KIND_W-1:0]     event_kind_i,
  input  wire logic [etpq_pkg::DATA_W-1:0]     payload_a_i,
  input  wire logic [etpq_pkg::DATA_W-1:0]     payload_b_i,
  output logic [1:0]                           status_o,
  output logic [etpq_pkg::TIME_W-1:0]          out_time_o,
  output logic [etpq_pkg::KIND_W-1:0]          out_kind_o,
  output logic [etpq_pkg::DATA_W-1:0]          out_payload_a_o,
  output logic [etpq_pkg::DATA_W-1:0]          out_payload_b_o,
  output logic                                 is_empty_o,
  output logic [etpq_pkg::CNT_W-1:0]           occupancy_o
);

  localparam int N = etpq_pkg::CAPACITY;

  etpq_pkg::entry_t                slot_q [N];
  etpq_pkg::entry_t                item_q;
  logic                            cmd_q;
  logic [N-1:0]                    le_q;
  logic [N-1:0]                    le_d;
  logic [etpq_pkg::CNT_W-1:0]      count_q;
  logic [etpq_pkg::CNT_W-1:0]      count_d;
  logic                            full;
  logic                            empty;
  logic                            ins_ok;
  logic                            rem_ok;
  logic [1:0]                      status_d;
  logic [etpq_pkg::TIME_BITS-1:0]  key;

  assign key    = event_time_i[etpq_pkg::TIME_BITS-1:0];
  assign full   = (count_q == etpq_pkg::CNT_W'(N));
  assign empty  = (count_q == '0);
  assign ins_ok = cmd_i.apply && (cmd_q == etpq_pkg::CMD_INSERT) && !full;
  assign rem_ok = cmd_i.apply && (cmd_q == etpq_pkg::CMD_REMOVE) && !empty;

  always_comb begin
    count_d  = count_q;
    status_d = etpq_pkg::ST_DONE;
    if (cmd_q == etpq_pkg::CMD_INSERT) begin
      if (full) status_d = etpq_pkg::ST_FULL;
      else      count_d  = count_q + etpq_pkg::CNT_W'(1);
    end else begin
      if (empty) status_d = etpq_pkg::ST_EMPTY;
      else       count_d  = count_q - etpq_pkg::CNT_W'(1);
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_slot
    assign le_d[g] = (etpq_pkg::CNT_W'(g) < count_q) && (slot_q[g].ev_time <= key);

    always_ff @(posedge clk_i) begin
      if (ins_ok && !le_q[g]) begin
        if (g == 0) begin
          slot_q[g] <= item_q;
        end else if (le_q[(g == 0) ? 0 : g-1]) begin
          slot_q[g] <= item_q;
        end else begin
          slot_q[g] <= slot_q[(g == 0) ? 0 : g-1];
        end
      end else if (rem_ok && (g < N-1)) begin
        slot_q[g] <= slot_q[(g < N-1) ? g+1 : g];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      cmd_q          <= command_i;
      le_q           <= le_d;
      item_q.ev_time <= key;
      item_q.kind    <= event_kind_i;
      item_q.pa      <= payload_a_i;
      item_q.pb      <= payload_b_i;
    end
    if (cmd_i.apply) begin
      status_o    <= status_d;
      is_empty_o  <= (count_d == '0);
      occupancy_o <= count_d;
      if (rem_ok) begin
        out_time_o      <= etpq_pkg::TIME_W'(slot_q[0].ev_time);
        out_kind_o      <= slot_q[0].kind;
        out_payload_a_o <= slot_q[0].pa;
        out_payload_b_o <= slot_q[0].pb;
      end else begin
        out_time_o      <= '0;
        out_kind_o      <= '0;
        out_payload_a_o <= '0;
        out_payload_b_o <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.apply) begin
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/event_time_priority_queue.sv
// top level of the event time priority queue
//
//  channel | direction | handshake               | fields
//  in      | input     | in_valid_i / in_stall_o | command, event_time, event_kind, payload a/b
//  out     | output    | out_valid_o/out_stall_i | status, out_time/kind/payload a/b, is_empty,
//          |           |                         | occupancy
//
// per word: the accept edge registers one time compare per slot; then, in the exec
// state, the slot row shifts and the output register loads; no new word is taken before then
// the exec state waits while a previous result word is still stalled
// reset clears the fill count and the controller state; slot contents need no clearing
`timescale 1ns / 1ps
`default_nettype none

module event_time_priority_queue (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic                            command_i,
  input  wire logic [etpq_pkg::TIME_W-1:0]     event_time_i,
  input  wire logic [etpq_pkg::KIND_W-1:0]     event_kind_i,
  input  wire logic [etpq_pkg::DATA_W-1:0]     payload_a_i,
  input  wire logic [etpq_pkg::DATA_W-1:0]     payload_b_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [1:0]                           status_o,
  output logic [etpq_pkg::TIME_W-1:0]          out_time_o,
  output logic [etpq_pkg::KIND_W-1:0]          out_kind_o,
  output logic [etpq_pkg::DATA_W-1:0]          out_payload_a_o,
  output logic [etpq_pkg::DATA_W-1:0]          out_payload_b_o,
  output logic                                 is_empty_o,
  output logic [etpq_pkg::CNT_W-1:0]           occupancy_o
);

  etpq_pkg::ctrl_cmd_t cmd;

  etpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  etpq_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .command_i       (command_i),
    .event_time_i    (event_time_i),
    .event_kind_i    (event_kind_i),
    .payload_a_i     (payload_a_i),
    .payload_b_i     (payload_b_i),
    .status_o        (status_o),
    .out_time_o      (out_time_o),
    .out_kind_o      (out_kind_o),
    .out_payload_a_o (out_payload_a_o),
    .out_payload_b_o (out_payload_b_o),
    .is_empty_o      (is_empty_o),
    .occupancy_o     (occupancy_o)
  );

endmodule

`default_nettype wire
